### rtl/assert_macros.svh
// Shared assertion macros; clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define TTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define TTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/tts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

    localparam int ROWS   = 10;
    localparam int COLS   = 10;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int POS_W  = 4;

    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CMD_CLEAR  = 8'h63; // c
    localparam logic [7:0] CMD_HOME   = 8'h68; // h
    localparam logic [7:0] CMD_BOL    = 8'h62; // b
    localparam logic [7:0] CMD_DOWN   = 8'h64; // d
    localparam logic [7:0] CMD_UP     = 8'h75; // u
    localparam logic [7:0] CMD_LEFT   = 8'h6C; // l
    localparam logic [7:0] CMD_RIGHT  = 8'h72; // r
    localparam logic [7:0] CMD_ERASE  = 8'h65; // e
    localparam logic [7:0] CMD_INSERT = 8'h69; // i
    localparam logic [7:0] CMD_OVER   = 8'h6F; // o

    localparam logic ACT_FEED = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [POS_W-1:0]  pos_t;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
        logic [3:0] read_row;
        logic [3:0] read_col;
    } in_item_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [3:0] cursor_row_out;
        logic [3:0] cursor_col_out;
        logic       insert_mode_out;
    } out_item_t;

    typedef struct packed {
        logic       we;
        addr_t      waddr;
        logic [7:0] wdata;
        logic       re;
        addr_t      raddr;
        logic       clr;
    } mem_req_t;

    function automatic addr_t cell_addr(input pos_t row, input pos_t col);
        return ADDR_W'(int'(row) * COLS + int'(col));
    endfunction

    function automatic pos_t clamp_pos(input logic [7:0] v, input int limit);
        return (v >= 8'(limit)) ? POS_W'(limit - 1) : v[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/text_terminal_screen_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Character-cell screen engine: raise start with an item while busy is low; the item is taken
// on that edge and its result appears on result for exactly one cycle with done high, which the
// receiver must capture then since it cannot stall the block. busy drops during the done cycle,
// so the next item can go in at once. A plain byte or a caret-caret write in overwrite mode (or
// at the last column) passes decode and one put write, and an in-range read decode and a read
// wait; cursor/mode commands, a lone caret, newlines, addressing digits, clear and an out-of-range
// read finish in decode; erase to end of line writes spaces from the cursor column to the row end,
// and an insert write first moves each cell from the row end down to the cursor column one place
// right, one cell per read/write pair through the single screen RAM port. Clear resets all per-cell
// valid flags together, so there is no clearing pass after reset.

module text_terminal_screen_engine_top
    import tts_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire in_item_t item,
    output logic          busy,
    output logic          done,
    output out_item_t     result
);

    mem_req_t   req;
    logic [7:0] rdata;

    tts_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result),
        .req    (req),
        .rdata  (rdata)
    );

    tts_screen_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rdata (rdata)
    );

endmodule

`default_nettype wire

### rtl/tts_screen_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module tts_screen_mem
    import tts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire mem_req_t   req,
    output logic [7:0]      rdata
);

    logic [7:0]       mem [CELLS];
    logic [CELLS-1:0] valid_reg;
    logic [7:0]       rdata_reg;
    logic             rvalid_reg;

    // Cells never written since reset or the last clear read as space.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clr)
        begin
            valid_reg <= '0;
        end
        else if (req.we)
        begin
            valid_reg[req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg  <= mem[req.raddr];
            rvalid_reg <= valid_reg[req.raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : CH_SPACE;

endmodule

`default_nettype wire

### rtl/tts_engine.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tts_engine
    import tts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire in_item_t   item,
    output logic            busy,
    output logic            done,
    output out_item_t       result,
    output mem_req_t        req,
    input  wire logic [7:0] rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_ERASE
    } state_t;

    state_t    state_reg,   state_next;
    in_item_t  item_reg,    item_next;
    pos_t      row_reg,     row_next;
    pos_t      col_reg,     col_next;
    pos_t      idx_reg,     idx_next;
    logic      ins_reg,     ins_next;
    logic      esc_reg,     esc_next;
    logic      colpend_reg, colpend_next;
    logic      done_reg,    done_next;
    out_item_t result_reg,  result_next;

    logic       finish;
    logic [7:0] rd_char;
    pos_t       idx_dec;
    logic [7:0] b;

    assign b       = item_reg.data_byte;
    assign idx_dec = idx_reg - POS_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        idx_next     = idx_reg;
        ins_next     = ins_reg;
        esc_next     = esc_reg;
        colpend_next = colpend_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        finish       = 1'b0;
        rd_char      = 8'h00;
        req          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                if (item_reg.action == ACT_READ)
                begin
                    if (item_reg.read_row < POS_W'(ROWS) && item_reg.read_col < POS_W'(COLS))
                    begin
                        req.re     = 1'b1;
                        req.raddr  = cell_addr(item_reg.read_row, item_reg.read_col);
                        state_next = S_RD_WAIT;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                else if (colpend_reg)
                begin
                    colpend_next = 1'b0;
                    col_next     = (b < CH_DIGIT0) ? '0 : clamp_pos(b - CH_DIGIT0, COLS);
                    finish       = 1'b1;
                end
                else if (esc_reg)
                begin
                    esc_next = 1'b0;
                    finish   = 1'b1;
                    unique case (b)
                        CMD_CLEAR:  req.clr = 1'b1;
                        CMD_HOME:
                        begin
                            row_next = '0;
                            col_next = '0;
                        end
                        CMD_BOL:    col_next = '0;
                        CMD_DOWN:   row_next = clamp_pos(8'(row_reg) + 8'd1, ROWS);
                        CMD_UP:     row_next = (row_reg != '0) ? row_reg - POS_W'(1) : row_reg;
                        CMD_LEFT:   col_next = (col_reg != '0) ? col_reg - POS_W'(1) : col_reg;
                        CMD_RIGHT:  col_next = clamp_pos(8'(col_reg) + 8'd1, COLS);
                        CMD_INSERT: ins_next = 1'b1;
                        CMD_OVER:   ins_next = 1'b0;
                        CMD_ERASE:
                        begin
                            finish     = 1'b0;
                            idx_next   = col_reg;
                            state_next = S_ERASE;
                        end
                        CH_CARET:
                        begin
                            finish = 1'b0;
                            if (ins_reg && col_reg < POS_W'(COLS - 1))
                            begin
                                idx_next   = POS_W'(COLS - 1);
                                state_next = S_SHIFT_RD;
                            end
                            else
                            begin
                                state_next = S_PUT;
                            end
                        end
                        default:
                        begin
                            if (b >= CH_DIGIT0 && b <= CH_DIGIT9)
                            begin
                                row_next     = clamp_pos(b - CH_DIGIT0, ROWS);
                                colpend_next = 1'b1;
                            end
                        end
                    endcase
                end
                else if (b == CH_CARET)
                begin
                    esc_next = 1'b1;
                    finish   = 1'b1;
                end
                else if (b == CH_NEWLINE)
                begin
                    finish = 1'b1;
                end
                else if (ins_reg && col_reg < POS_W'(COLS - 1))
                begin
                    idx_next   = POS_W'(COLS - 1);
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end

            S_RD_WAIT:
            begin
                rd_char = rdata;
                finish  = 1'b1;
            end

            // Shift right one cell per read/write pair, from the row end down.
            S_SHIFT_RD:
            begin
                req.re     = 1'b1;
                req.raddr  = cell_addr(row_reg, idx_dec);
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                req.we    = 1'b1;
                req.waddr = cell_addr(row_reg, idx_reg);
                req.wdata = rdata;
                idx_next  = idx_dec;
                if (idx_dec == col_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    state_next = S_SHIFT_RD;
                end
            end

            S_PUT:
            begin
                req.we    = 1'b1;
                req.waddr = cell_addr(row_reg, col_reg);
                req.wdata = b;
                col_next  = clamp_pos(8'(col_reg) + 8'd1, COLS);
                finish    = 1'b1;
            end

            S_ERASE:
            begin
                req.we    = 1'b1;
                req.waddr = cell_addr(row_reg, idx_reg);
                req.wdata = CH_SPACE;
                idx_next  = idx_reg + POS_W'(1);
                if (idx_reg == POS_W'(COLS - 1))
                begin
                    finish = 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next  = S_IDLE;
            done_next   = 1'b1;
            result_next = '{cell_char:       rd_char,
                            cursor_row_out:  row_next,
                            cursor_col_out:  col_next,
                            insert_mode_out: ins_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            item_reg    <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            idx_reg     <= '0;
            ins_reg     <= 1'b0;
            esc_reg     <= 1'b0;
            colpend_reg <= 1'b0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            item_reg    <= item_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            idx_reg     <= idx_next;
            ins_reg     <= ins_next;
            esc_reg     <= esc_next;
            colpend_reg <= colpend_next;
            done_reg    <= done_next;
            result_reg  <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `TTS_ASSERT_IMP(a_done_after_work, done_reg, $past(state_reg != S_IDLE), "result without work")
    `TTS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "transfer did not start work")
    `TTS_ASSERT(a_cursor_range, row_reg < POS_W'(ROWS) && col_reg < POS_W'(COLS), "cursor off screen")
    `TTS_ASSERT(a_one_mem_op, !(req.we && (req.re || req.clr)), "conflicting screen accesses")

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tts_pkg::*;

    class screen_scoreboard;
        logic [7:0] cells [ROWS][COLS];
        pos_t       cur_row;
        pos_t       cur_col;
        logic       ins_mode;
        logic       caret_seen;
        logic       col_digit_due;
        out_item_t  expected_views [$];
        int         mismatches;

        function new();
            blank_screen();
            cur_row       = '0;
            cur_col       = '0;
            ins_mode      = 1'b0;
            caret_seen    = 1'b0;
            col_digit_due = 1'b0;
            mismatches    = 0;
        endfunction

        function void blank_screen();
            foreach (cells[r, c])
                cells[r][c] = CH_SPACE;
        endfunction

        function int held(int v, int lim);
            return (v >= lim) ? lim - 1 : v;
        endfunction

        function void write_char(logic [7:0] ch);
            int c;
            c = cur_col;
            if (ins_mode)
            begin
                for (int i = COLS - 1; i > c; i--)
                    cells[cur_row][i] = cells[cur_row][i - 1];
            end
            cells[cur_row][c] = ch;
            cur_col = pos_t'(held(c + 1, COLS));
        endfunction

        function void run_command(logic [7:0] b);
            case (b)
                CMD_CLEAR:  blank_screen();
                CMD_HOME:
                begin
                    cur_row = '0;
                    cur_col = '0;
                end
                CMD_BOL:    cur_col = '0;
                CMD_DOWN:   cur_row = pos_t'(held(int'(cur_row) + 1, ROWS));
                CMD_UP:     if (cur_row > 0) cur_row = cur_row - 1'b1;
                CMD_LEFT:   if (cur_col > 0) cur_col = cur_col - 1'b1;
                CMD_RIGHT:  cur_col = pos_t'(held(int'(cur_col) + 1, COLS));
                CMD_ERASE:
                begin
                    for (int i = cur_col; i < COLS; i++)
                        cells[cur_row][i] = CH_SPACE;
                end
                CMD_INSERT: ins_mode = 1'b1;
                CMD_OVER:   ins_mode = 1'b0;
                CH_CARET:   write_char(CH_CARET);
                default:
                begin
                    if (b >= CH_DIGIT0 && b <= CH_DIGIT9)
                    begin
                        cur_row = pos_t'(held(int'(b) - int'(CH_DIGIT0), ROWS));
                        col_digit_due = 1'b1;
                    end
                end
            endcase
        endfunction

        function void take_byte(logic [7:0] b);
            if (col_digit_due)
            begin
                col_digit_due = 1'b0;
                cur_col = (b < CH_DIGIT0) ? pos_t'(0)
                        : pos_t'(held(int'(b) - int'(CH_DIGIT0), COLS));
            end
            else if (caret_seen)
            begin
                caret_seen = 1'b0;
                run_command(b);
            end
            else if (b == CH_CARET)
                caret_seen = 1'b1;
            else if (b != CH_NEWLINE)
                write_char(b);
        endfunction

        function void note_transfer(in_item_t it);
            out_item_t v;
            v = '0;
            if (it.action == ACT_FEED)
                take_byte(it.data_byte);
            else if (it.read_row < ROWS && it.read_col < COLS)
                v.cell_char = cells[it.read_row][it.read_col];
            v.cursor_row_out  = cur_row;
            v.cursor_col_out  = cur_col;
            v.insert_mode_out = ins_mode;
            expected_views.push_back(v);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_views.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result char=%h row=%0d col=%0d ins=%0b",
                             $realtime, got.cell_char, got.cursor_row_out,
                             got.cursor_col_out, got.insert_mode_out);
                return;
            end
            want = expected_views.pop_front();
            if (got.cell_char !== want.cell_char
                || got.cursor_row_out !== want.cursor_row_out
                || got.cursor_col_out !== want.cursor_col_out
                || got.insert_mode_out !== want.insert_mode_out)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $write("%0t: result mismatch exp char=%h row=%0d col=%0d ins=%0b",
                           $realtime, want.cell_char, want.cursor_row_out,
                           want.cursor_col_out, want.insert_mode_out);
                    $display(" got char=%h row=%0d col=%0d ins=%0b",
                             got.cell_char, got.cursor_row_out,
                             got.cursor_col_out, got.insert_mode_out);
                end
            end
        endfunction
    endclass

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_item_t  item  = '0;
    logic      busy;
    logic      done;
    out_item_t result;

    screen_scoreboard board = new();
    int items_sent = 0;

    text_terminal_screen_engine_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_transfer(item);
            if (done)
                board.check_result(result);
        end
    end

    function automatic in_item_t feed_item(logic [7:0] b);
        in_item_t it;
        it.action    = ACT_FEED;
        it.data_byte = b;
        it.read_row  = 4'($urandom_range(0, 15));
        it.read_col  = 4'($urandom_range(0, 15));
        return it;
    endfunction

    function automatic in_item_t read_item(int r, int c);
        in_item_t it;
        it.action    = ACT_READ;
        it.data_byte = 8'($urandom_range(0, 255));
        it.read_row  = 4'(r);
        it.read_col  = 4'(c);
        return it;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(in_item_t it);
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic pace(int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(negedge clk);
        end
    endtask

    task automatic send_feed(logic [7:0] b, int pct);
        send_item(feed_item(b));
        pace(pct);
    endtask

    task automatic random_sequence(int pct);
        int         pick;
        logic [7:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            send_feed(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(8'h21, 8'h7E)), pct);
        else if (pick < 60)
        begin
            case ($urandom_range(0, 21))
                0:       cmd = CMD_CLEAR;
                1, 2:    cmd = CMD_HOME;
                3, 4:    cmd = CMD_BOL;
                5, 6:    cmd = CMD_DOWN;
                7, 8:    cmd = CMD_UP;
                9, 10:   cmd = CMD_LEFT;
                11, 12:  cmd = CMD_RIGHT;
                13:      cmd = CMD_ERASE;
                14, 15:  cmd = CMD_INSERT;
                16, 17:  cmd = CMD_OVER;
                18, 19:  cmd = CH_CARET;
                default: cmd = 8'($urandom_range(0, 255));
            endcase
            send_feed(CH_CARET, pct);
            send_feed(cmd, pct);
        end
        else if (pick < 72)
        begin
            send_feed(CH_CARET, pct);
            send_feed(CH_DIGIT0 + 8'($urandom_range(0, 9)), pct);
            send_feed(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                   : CH_DIGIT0 + 8'($urandom_range(0, 9)), pct);
        end
        else if (pick < 90)
        begin
            send_item(read_item(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                             : $urandom_range(0, 9),
                                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                             : $urandom_range(0, 9)));
            pace(pct);
        end
        else
            send_feed(8'($urandom_range(0, 255)), pct);
    endtask

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int idle_pct [3];
        int drain;
        idle_pct = '{0, 79, 12};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: field extremes, modes, caret escape, addressing clamps
        send_feed(8'h41, 0);
        send_feed(8'hFF, 0);
        send_feed(CH_CARET, 0);
        send_feed(CMD_INSERT, 0);
        send_feed(8'h00, 0);
        send_feed(CH_CARET, 0);
        send_feed(CMD_OVER, 0);
        send_feed(CH_NEWLINE, 0);
        send_feed(CH_CARET, 0);
        send_feed(CH_CARET, 0);
        send_feed(CH_CARET, 0);
        send_feed(CH_DIGIT9, 0);
        send_feed(8'hFF, 0);
        send_feed(CH_CARET, 0);
        send_feed(CH_DIGIT0, 0);
        send_feed(CH_NEWLINE, 0);
        send_feed(CH_CARET, 0);
        send_feed(CMD_ERASE, 0);
        send_item(read_item(9, 9));
        send_item(read_item(15, 15));
        send_item(read_item(0, 10));
        send_feed(CH_CARET, 0);
        send_feed(CMD_CLEAR, 0);

        for (int p = 0; p < 3; p++)
        begin
            while (items_sent < 25 + (p + 1) * 300)
                random_sequence(idle_pct[p]);
        end
        start <= 1'b0;

        drain = 0;
        while (board.expected_views.size() != 0 && drain < 1000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (40) @(posedge clk);

        if (board.mismatches == 0 && board.expected_views.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
